FILE: src/cma_pkg.sv
// cma_pkg: constants, types and marker helper for the cluster map allocator
// used by cma_ctrl, cma_datapath and cluster_map_allocator
package cma_pkg;

	localparam int MAP_ENTRIES   = 1024;
	localparam int CLUSTER_BYTES = 16384;
	localparam int IDX_W         = $clog2(MAP_ENTRIES);
	localparam int PTR_W         = IDX_W + 1;
	localparam int LOG_CB        = $clog2(CLUSTER_BYTES);
	localparam int NEED_W        = 16;
	localparam int FREE_W        = 11;

	localparam logic [31:0] BIG_LIMIT = 32'd5242880;

	localparam logic [7:0] MARK_SMALL = 8'hAA;
	localparam logic [7:0] MARK_BB    = 8'hBB;
	localparam logic [7:0] MARK_CC    = 8'hCC;
	localparam logic [7:0] MARK_FF    = 8'hFF;
	localparam logic [7:0] QUAD_0     = 8'hFE;
	localparam logic [7:0] QUAD_1     = 8'hDC;
	localparam logic [7:0] QUAD_2     = 8'hBA;
	localparam logic [7:0] QUAD_3     = 8'hB8;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NO_ROOM  = 2'd1,
		ST_TOO_BIG  = 2'd2,
		ST_BAD_FREE = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_CLEAR, PH_SCAN, PH_MARK, PH_PEEK, PH_WIPE
	} phase_t;

	typedef enum logic [1:0] {
		FK_NONE, FK_SMALL, FK_QUAD, FK_BIG
	} kind_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_MARK, S_PEEK, S_JUDGE, S_WIPE, S_FINISH
	} state_t;

	typedef struct packed {
		phase_t phase;
		logic   start;
		logic   judge;
	} cmd_t;

	typedef struct packed {
		logic  clr_done;
		logic  is_free;
		logic  too_big;
		logic  bad_addr;
		logic  found;
		logic  scan_fail;
		logic  mark_done;
		logic  peek_done;
		kind_t kind;
		logic  wipe_done;
	} sts_t;

	// byte written at position k of a freshly allocated block of need entries
	function automatic logic [7:0] mark_byte(input logic [NEED_W-1:0] need,
			input logic [NEED_W-1:0] k);
		logic [7:0] b;
		if (need == NEED_W'(1)) begin
			b = MARK_SMALL;
		end else if (need == NEED_W'(4)) begin
			case (k[1:0])
				2'd0:    b = QUAD_0;
				2'd1:    b = QUAD_1;
				2'd2:    b = QUAD_2;
				default: b = QUAD_3;
			endcase
		end else if (k == '0 || k == need - NEED_W'(1)) begin
			b = MARK_BB;
		end else if (k == NEED_W'(1) || k == need - NEED_W'(2)) begin
			b = MARK_CC;
		end else begin
			b = MARK_FF;
		end
		return b;
	endfunction

endpackage

FILE: src/cma_datapath.sv
// cma_datapath: cluster map memory, scan pointers, run counter, peek window
// and free-entry count; depends on cma_pkg
module cma_datapath import cma_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic                opcode,
	input  logic [31:0]         request_size,
	input  logic [31:0]         release_address,
	input  logic [31:0]         base,
	output sts_t                sts,
	output logic [31:0]         blk_addr,
	output logic [FREE_W-1:0]   free_cnt
);

	logic [7:0]            map_mem [MAP_ENTRIES];
	logic [7:0]            rd_data_s1;
	logic                  vld_s1;
	logic [IDX_W-1:0]      addr_s1;
	logic [PTR_W-1:0]      ptr_q;
	logic [PTR_W-1:0]      run_q;
	logic [PTR_W-1:0]      zero_q;
	logic [NEED_W-1:0]     need_q;
	logic [NEED_W-1:0]     k_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      start_q;
	logic                  op_q;
	logic                  too_big_q;
	logic                  bad_q;
	logic [7:0]            win_q [4];
	logic [7:0]            prev_q;
	kind_t                 kind_q;

	logic [31:0]           off;
	logic [31-LOG_CB:0]    idx_full;
	logic [NEED_W-1:0]     need_d;
	logic                  issue;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [7:0]            mem_wdata;
	logic [PTR_W-1:0]      run_inc;
	logic [IDX_W-1:0]      start_d;
	kind_t                 kind_d;
	logic                  found;
	logic                  at_last;

	// address decode and size classification for a new item
	assign off      = release_address - base;
	assign idx_full = off[31:LOG_CB];

	always_comb begin
		if (request_size <= 32'(CLUSTER_BYTES)) begin
			need_d = NEED_W'(1);
		end else if (request_size <= 32'(4 * CLUSTER_BYTES)) begin
			need_d = NEED_W'(4);
		end else begin
			need_d = NEED_W'(request_size >> LOG_CB) + NEED_W'(1);
		end
	end

	// first-fit run tracking on streamed read data
	assign run_inc = run_q + PTR_W'(1);
	assign found   = (cmd.phase == PH_SCAN) && vld_s1 && (rd_data_s1 == 8'h00)
		&& (32'(run_inc) == 32'(need_q));
	assign start_d = addr_s1 + IDX_W'(1) - IDX_W'(need_q);
	assign at_last = (addr_s1 == IDX_W'(MAP_ENTRIES - 1));

	// marker check on the four peeked entries
	always_comb begin
		if (win_q[0] == MARK_SMALL) begin
			kind_d = FK_SMALL;
		end else if (32'(idx_q) <= 32'(MAP_ENTRIES - 4) && win_q[0] == QUAD_0
				&& win_q[1] == QUAD_1 && win_q[2] == QUAD_2 && win_q[3] == QUAD_3) begin
			kind_d = FK_QUAD;
		end else if (32'(idx_q) <= 32'(MAP_ENTRIES - 3) && win_q[0] == MARK_BB
				&& win_q[1] == MARK_CC && win_q[2] == MARK_FF) begin
			kind_d = FK_BIG;
		end else begin
			kind_d = FK_NONE;
		end
	end

	// read issue per phase
	always_comb begin
		unique case (cmd.phase)
			PH_SCAN, PH_WIPE: issue = (ptr_q < PTR_W'(MAP_ENTRIES));
			PH_PEEK:          issue = 1'b1;
			default:          issue = 1'b0;
		endcase
	end

	// write port select
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q[IDX_W-1:0];
		mem_wdata = 8'h00;
		unique case (cmd.phase)
			PH_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = (ptr_q == '0) ? MARK_FF : 8'h00;
			end
			PH_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = mark_byte(need_q, k_q);
			end
			PH_WIPE: begin
				mem_we    = vld_s1;
				mem_waddr = addr_s1;
			end
			default: mem_we = 1'b0;
		endcase
	end

	// map memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= map_mem[ptr_q[IDX_W-1:0]];
		end
		addr_s1 <= ptr_q[IDX_W-1:0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			vld_s1 <= 1'b0;
			run_q  <= '0;
			k_q    <= '0;
			zero_q <= PTR_W'(MAP_ENTRIES - 1);
			kind_q <= FK_NONE;
		end else begin
			vld_s1 <= issue;
			if (cmd.start) begin
				ptr_q <= (opcode == OP_FREE) ? {1'b0, idx_full[IDX_W-1:0]} : PTR_W'(1);
				run_q <= '0;
				k_q   <= '0;
			end else if (cmd.judge) begin
				ptr_q  <= {1'b0, idx_q};
				k_q    <= '0;
				kind_q <= kind_d;
			end else begin
				unique case (cmd.phase)
					PH_CLEAR: ptr_q <= ptr_q + PTR_W'(1);
					PH_SCAN: begin
						if (found) begin
							ptr_q <= {1'b0, start_d};
							k_q   <= '0;
						end else begin
							if (issue) begin
								ptr_q <= ptr_q + PTR_W'(1);
							end
							if (vld_s1) begin
								run_q <= (rd_data_s1 == 8'h00) ? run_inc : '0;
							end
						end
					end
					PH_MARK: begin
						ptr_q  <= ptr_q + PTR_W'(1);
						k_q    <= k_q + NEED_W'(1);
						zero_q <= zero_q - PTR_W'(1);
					end
					PH_PEEK: begin
						ptr_q <= ptr_q + PTR_W'(1);
						if (vld_s1) begin
							k_q <= k_q + NEED_W'(1);
						end
					end
					PH_WIPE: begin
						if (issue) begin
							ptr_q <= ptr_q + PTR_W'(1);
						end
						if (vld_s1) begin
							k_q <= k_q + NEED_W'(1);
							if (rd_data_s1 != 8'h00) begin
								zero_q <= zero_q + PTR_W'(1);
							end
						end
					end
					default: ptr_q <= ptr_q;
				endcase
			end
		end
	end

	// item payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q      <= opcode;
			too_big_q <= (request_size > BIG_LIMIT);
			bad_q     <= (off[LOG_CB-1:0] != '0)
				|| (idx_full >= (32-LOG_CB)'(MAP_ENTRIES));
			idx_q     <= idx_full[IDX_W-1:0];
			need_q    <= need_d;
		end
		if (found) begin
			start_q <= start_d;
		end
		if (cmd.phase == PH_PEEK && vld_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= rd_data_s1;
		end
		if (cmd.phase == PH_WIPE && vld_s1) begin
			prev_q <= rd_data_s1;
		end
	end

	// status back to the controller
	always_comb begin
		sts.clr_done  = (cmd.phase == PH_CLEAR) && (ptr_q == PTR_W'(MAP_ENTRIES - 1));
		sts.is_free   = op_q;
		sts.too_big   = too_big_q;
		sts.bad_addr  = bad_q;
		sts.found     = found;
		sts.scan_fail = (cmd.phase == PH_SCAN) && vld_s1 && at_last && !found;
		sts.mark_done = (cmd.phase == PH_MARK) && (k_q == need_q - NEED_W'(1));
		sts.peek_done = (cmd.phase == PH_PEEK) && vld_s1 && (k_q == NEED_W'(3));
		sts.kind      = kind_d;
		sts.wipe_done = (cmd.phase == PH_WIPE) && vld_s1 && (
			(kind_q == FK_SMALL && k_q == '0) ||
			(kind_q == FK_QUAD && k_q == NEED_W'(3)) ||
			(kind_q == FK_BIG && ((k_q != '0 && prev_q == MARK_CC
				&& rd_data_s1 == MARK_BB) || at_last)));
	end

	assign blk_addr = base + 32'({start_q, LOG_CB'(0)});
	assign free_cnt = FREE_W'(zero_q);

	// free-entry count never exceeds the allocatable entries
	a_zero_bound: assert property (@(posedge clk) disable iff (!arst_n)
		zero_q <= PTR_W'(MAP_ENTRIES - 1))
		else $error("free-entry count out of range");

	// marking writes stay inside the map
	a_mark_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.phase == PH_MARK |-> ptr_q < PTR_W'(MAP_ENTRIES))
		else $error("marking write past map end");

	// wipe never clears below the freed block
	a_wipe_from_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.phase == PH_WIPE && vld_s1) |-> addr_s1 >= idx_q)
		else $error("wipe below block start");

endmodule

FILE: src/cma_ctrl.sv
// cma_ctrl: sequencer for clearing, allocate scan/mark and free peek/wipe
// depends on cma_pkg
module cma_ctrl import cma_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  slot_free,
	input  sts_t  sts,
	output cmd_t  cmd,
	output logic  in_stall,
	output logic  emit,
	output stat_t res_status
);

	state_t state_q, state_d;
	stat_t  stat_q, stat_d;

	// next state
	always_comb begin
		state_d = state_q;
		stat_d  = stat_q;
		unique case (state_q)
			S_CLEAR:  if (sts.clr_done) state_d = S_IDLE;
			S_IDLE:   if (in_valid) state_d = S_CHECK;
			S_CHECK: begin
				if (sts.is_free) begin
					if (sts.bad_addr) begin
						state_d = S_FINISH;
						stat_d  = ST_BAD_FREE;
					end else begin
						state_d = S_PEEK;
					end
				end else if (sts.too_big) begin
					state_d = S_FINISH;
					stat_d  = ST_TOO_BIG;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.found) begin
					state_d = S_MARK;
				end else if (sts.scan_fail) begin
					state_d = S_FINISH;
					stat_d  = ST_NO_ROOM;
				end
			end
			S_MARK: begin
				if (sts.mark_done) begin
					state_d = S_FINISH;
					stat_d  = ST_DONE;
				end
			end
			S_PEEK:   if (sts.peek_done) state_d = S_JUDGE;
			S_JUDGE: begin
				state_d = S_FINISH;
				if (sts.kind == FK_NONE) begin
					stat_d = ST_BAD_FREE;
				end else begin
					state_d = S_WIPE;
				end
			end
			S_WIPE: begin
				if (sts.wipe_done) begin
					state_d = S_FINISH;
					stat_d  = ST_DONE;
				end
			end
			S_FINISH: if (slot_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.start = 1'b0;
		cmd.judge = 1'b0;
		emit      = 1'b0;
		in_stall  = 1'b1;
		unique case (state_q)
			S_CLEAR:  cmd.phase = PH_CLEAR;
			S_IDLE: begin
				cmd.phase = PH_IDLE;
				in_stall  = 1'b0;
				cmd.start = in_valid;
			end
			S_SCAN:   cmd.phase = PH_SCAN;
			S_MARK:   cmd.phase = PH_MARK;
			S_PEEK:   cmd.phase = PH_PEEK;
			S_JUDGE: begin
				cmd.phase = PH_IDLE;
				cmd.judge = 1'b1;
			end
			S_WIPE:   cmd.phase = PH_WIPE;
			S_FINISH: begin
				cmd.phase = PH_IDLE;
				emit      = slot_free;
			end
			default:  cmd.phase = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			stat_q  <= ST_DONE;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
		end
	end

	assign res_status = stat_q;

endmodule

FILE: src/cluster_map_allocator.sv
// cluster_map_allocator: top level, config register and result register
// depends on cma_pkg, cma_ctrl and cma_datapath
// allocate: first-fit scan reading one map entry per cycle, then marking of need entries
// free: peek of four entries, then wipe scan
// one item at a time; the result register lets the next item enter while a result waits
// after reset a clearing pass over all MAP_ENTRIES (1024) entries runs with in_stall high
module cluster_map_allocator import cma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	input  logic [31:0]       request_size,
	input  logic [31:0]       release_address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [31:0]       block_address,
	output logic [FREE_W-1:0] free_entries
);

	logic [31:0]       base_q;
	cmd_t              cmd;
	sts_t              sts;
	logic              emit;
	logic              slot_free;
	stat_t             res_status;
	logic [31:0]       blk_addr;
	logic [FREE_W-1:0] free_cnt;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [31:0]       addr_q;
	logic [FREE_W-1:0] free_q;

	// base address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_write) begin
			base_q <= cfg_data;
		end
	end

	cma_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.slot_free  (slot_free),
		.sts        (sts),
		.cmd        (cmd),
		.in_stall   (in_stall),
		.emit       (emit),
		.res_status (res_status)
	);

	cma_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.opcode          (opcode),
		.request_size    (request_size),
		.release_address (release_address),
		.base            (base_q),
		.sts             (sts),
		.blk_addr        (blk_addr),
		.free_cnt        (free_cnt)
	);

	// result register
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= res_status;
			addr_q   <= (res_status == ST_DONE && !sts.is_free) ? blk_addr : 32'd0;
			free_q   <= free_cnt;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign block_address = addr_q;
	assign free_entries  = free_q;

endmodule
